### rtl/core/dqi_pkg.sv
// Package for the indexed double-ended queue: sizes, request and status codes,
// and the operation record passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

package dqi_pkg;

    // Ring geometry; DEPTH is a power of two so slot arithmetic wraps by truncation
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIRST      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LAST       = 3'd5;
    localparam logic [REQ_W-1:0] REQ_READ_POS   = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(DEPTH);

    // One classified request: memory action plus the answer fields known up front
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } dqi_op_t;

endpackage

### rtl/core/dqi_front.sv
// Front part: accepts requests, holds the front pointer and the count,
// and classifies each request into a memory operation. Depends on dqi_pkg.
`timescale 1ns / 1ps

module dqi_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [dqi_pkg::REQ_W-1:0]    req_type,
    input  logic [dqi_pkg::DATA_W-1:0]   entry_data,
    input  logic [dqi_pkg::POS_W-1:0]    position,
    output dqi_pkg::dqi_op_t             op
);
    import dqi_pkg::*;

    logic [ADDR_W-1:0] front_reg;
    logic [ADDR_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] last_slot;
    logic              is_empty;
    logic              is_full;

    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == COUNT_FULL);
    assign last_slot = front_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);

    // Classify the request and work out the new pointer and count
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        op.wr      = 1'b0;
        op.rd      = 1'b0;
        op.addr    = front_reg;
        op.wdata   = entry_data;
        op.status  = ST_OK;
        unique case (req_type)
            REQ_PUSH_FRONT:
            begin
                if (is_full)
                    op.status = ST_FULL;
                else
                begin
                    front_next = front_reg - ADDR_W'(1);
                    op.addr    = front_next;
                    op.wr      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK:
            begin
                if (is_full)
                    op.status = ST_FULL;
                else
                begin
                    op.addr    = front_reg + count_reg[ADDR_W-1:0];
                    op.wr      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_FIRST:
            begin
                if (is_empty)
                    op.status = ST_EMPTY;
                else
                begin
                    op.rd = 1'b1;
                    if (req_type == REQ_POP_FRONT)
                    begin
                        front_next = front_reg + ADDR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            REQ_POP_BACK, REQ_LAST:
            begin
                if (is_empty)
                    op.status = ST_EMPTY;
                else
                begin
                    op.addr = last_slot;
                    op.rd   = 1'b1;
                    if (req_type == REQ_POP_BACK)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_READ_POS:
            begin
                if (is_empty)
                    op.status = ST_EMPTY;
                else if (CNT_W'(position) >= count_reg)
                    op.status = ST_RANGE;
                else
                begin
                    op.addr = front_reg + ADDR_W'(position);
                    op.rd   = 1'b1;
                end
            end
            default:
            begin
                // unused code: no action, report the count as is
            end
        endcase
        op.count = count_next;
    end

    // Advance pointer and count on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/dqi_fifo.sv
// Two-entry queue of classified operations between front and back parts.
// Depends on dqi_pkg.
`timescale 1ns / 1ps

module dqi_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dqi_pkg::dqi_op_t  push_op,
    output logic              full,
    output logic              valid,
    input  logic              pop,
    output dqi_pkg::dqi_op_t  pop_op
);
    import dqi_pkg::*;

    dqi_op_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign pop_op  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    // Hold the payload of each transfer in
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

endmodule

### rtl/core/dqi_back.sv
// Back part: holds the ring memory, carries out each operation and
// registers the result. Depends on dqi_pkg.
`timescale 1ns / 1ps

module dqi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  dqi_pkg::dqi_op_t              op,
    output logic                          op_pop,
    output logic                          done,
    output logic [dqi_pkg::DATA_W-1:0]    result_data,
    output logic [dqi_pkg::STAT_W-1:0]    status,
    output logic [dqi_pkg::CNT_W-1:0]     entry_count
);
    import dqi_pkg::*;

    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              rd_reg;
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]  count_reg;

    // The back part never stalls: take an operation whenever one waits
    assign op_pop = op_valid;

    // Write or read one ring slot
    always_ff @(posedge clk)
    begin
        if (op_valid && op.wr)
            ring_mem[op.addr] <= op.wdata;
        if (op_valid && op.rd)
            rdata_reg <= ring_mem[op.addr];
    end

    // Hold the answer fields alongside the read
    always_ff @(posedge clk)
    begin
        if (op_valid)
        begin
            rd_reg     <= op.rd;
            status_reg <= op.status;
            count_reg  <= op.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= op_valid;
    end

    // Drive zero data for anything that did not read
    assign done        = done_reg;
    assign result_data = rd_reg ? rdata_reg : '0;
    assign status      = status_reg;
    assign entry_count = count_reg;

endmodule

### rtl/core/double_ended_queue_indexed_core.sv
// Top level of the indexed double-ended queue: front part, operation queue,
// back part with the ring memory. Depends on dqi_pkg, dqi_front, dqi_fifo, dqi_back.
//
//  channel   | handshake        | fields
//  ----------+------------------+----------------------------------------
//  request   | start / busy     | req_type, entry_data, position
//  result    | done (strobe)    | result_data, status, entry_count
//
// One request can be taken every cycle; its result strobes once the transfer
// has passed the operation queue and then the registered read port of the ring
// memory.
// Reset clears the front pointer, the count and the queue; memory contents
// are undefined until pushed. busy rises only if the operation queue fills,
// which does not happen since results cannot be held off.
`timescale 1ns / 1ps

module double_ended_queue_indexed_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dqi_pkg::REQ_W-1:0]     req_type,
    input  logic [dqi_pkg::DATA_W-1:0]    entry_data,
    input  logic [dqi_pkg::POS_W-1:0]     position,
    output logic                          done,
    output logic [dqi_pkg::DATA_W-1:0]    result_data,
    output logic [dqi_pkg::STAT_W-1:0]    status,
    output logic [dqi_pkg::CNT_W-1:0]     entry_count
);
    import dqi_pkg::*;

    dqi_op_t front_op;
    dqi_op_t back_op;
    logic    take;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;

    assign busy = q_full;
    assign take = start && !q_full;

    dqi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .req_type   (req_type),
        .entry_data (entry_data),
        .position   (position),
        .op         (front_op)
    );

    dqi_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .push_op (front_op),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .pop_op  (back_op)
    );

    dqi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (q_valid),
        .op          (back_op),
        .op_pop      (q_pop),
        .done        (done),
        .result_data (result_data),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

### rtl/core/dqi_checker.sv
// Port-level checker for the indexed double-ended queue, bound to the top level.
// Depends on dqi_pkg and double_ended_queue_indexed_core.
`timescale 1ns / 1ps

module dqi_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic [dqi_pkg::DATA_W-1:0]    result_data,
    input  logic [dqi_pkg::STAT_W-1:0]    status,
    input  logic [dqi_pkg::CNT_W-1:0]     entry_count
);
    import dqi_pkg::*;

    // Every transfer in gives a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("request transfer not answered");

    // No result without an earlier transfer
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without request");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_data == '0))
        else $error("nonzero data with failing status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == COUNT_FULL))
        else $error("full status with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind double_ended_queue_indexed_core dqi_checker u_dqi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_data (result_data),
    .status      (status),
    .entry_count (entry_count)
);

### bench/double_ended_queue_indexed_core_tb.sv
// Self-checking testbench for double_ended_queue_indexed_core: directed table, then random
// request traffic checked against a ring-buffer predictor. Depends on dqi_pkg and the core.
`timescale 1ns / 1ps

module double_ended_queue_indexed_core_tb;

    import dqi_pkg::*;

    localparam int RANDOM_ITEMS  = 900;
    localparam int MAX_GAP       = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SHOWN_LIMIT   = 10;
    localparam int TABLE_ROWS    = 25;

    // Request code the block leaves unused; it must answer ok with no change
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } deque_answer_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] word;
        logic [POS_W-1:0]  pos;
        bit                typed;
        deque_answer_t     answer;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] entry_data;
    logic [POS_W-1:0]  position;
    logic              done;
    logic [DATA_W-1:0] result_data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;

    // Shadow copy of the ring, its front slot and its fill level
    logic [DATA_W-1:0] shadow_ring [DEPTH];
    logic [ADDR_W-1:0] shadow_head;
    logic [CNT_W-1:0]  shadow_held;

    deque_answer_t pending_answers [$];
    int            error_count = 0;
    int            shown_count = 0;
    int            issued      = 0;
    int            cycle_count = 0;
    bit            steady      = 1'b0;

    double_ended_queue_indexed_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_data  (entry_data),
        .position    (position),
        .done        (done),
        .result_data (result_data),
        .status      (status),
        .entry_count (entry_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the shadow deque and return the answer it must give
    function automatic deque_answer_t deque_apply(input logic [REQ_W-1:0] req,
                                                  input logic [DATA_W-1:0] word,
                                                  input logic [POS_W-1:0] pos);
        deque_answer_t ans;
        logic [ADDR_W-1:0] slot;
        ans.data   = '0;
        ans.status = ST_OK;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (shadow_held == COUNT_FULL)
                    ans.status = ST_FULL;
                else if (req == REQ_PUSH_FRONT)
                begin
                    shadow_head = shadow_head - ADDR_W'(1);
                    shadow_ring[shadow_head] = word;
                    shadow_held = shadow_held + CNT_W'(1);
                end
                else
                begin
                    slot = shadow_head + shadow_held[ADDR_W-1:0];
                    shadow_ring[slot] = word;
                    shadow_held = shadow_held + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_FIRST, REQ_LAST:
            begin
                if (shadow_held == '0)
                    ans.status = ST_EMPTY;
                else if (req == REQ_POP_FRONT || req == REQ_FIRST)
                begin
                    ans.data = shadow_ring[shadow_head];
                    if (req == REQ_POP_FRONT)
                    begin
                        shadow_head = shadow_head + ADDR_W'(1);
                        shadow_held = shadow_held - CNT_W'(1);
                    end
                end
                else
                begin
                    slot = shadow_head + shadow_held[ADDR_W-1:0] - ADDR_W'(1);
                    ans.data = shadow_ring[slot];
                    if (req == REQ_POP_BACK)
                        shadow_held = shadow_held - CNT_W'(1);
                end
            end
            REQ_READ_POS:
            begin
                // empty wins over out of range
                if (shadow_held == '0)
                    ans.status = ST_EMPTY;
                else if (CNT_W'(pos) >= shadow_held)
                    ans.status = ST_RANGE;
                else
                begin
                    slot = shadow_head + pos;
                    ans.data = shadow_ring[slot];
                end
            end
            default: ;
        endcase
        ans.count = shadow_held;
        return ans;
    endfunction

    function automatic stim_row_t make_row(input logic [REQ_W-1:0] req,
                                           input logic [DATA_W-1:0] word,
                                           input logic [POS_W-1:0] pos,
                                           input bit typed,
                                           input logic [DATA_W-1:0] data,
                                           input logic [STAT_W-1:0] stat,
                                           input int count);
        stim_row_t r;
        r.req           = req;
        r.word          = word;
        r.pos           = pos;
        r.typed         = typed;
        r.answer.data   = data;
        r.answer.status = stat;
        r.answer.count  = CNT_W'(count);
        return r;
    endfunction

    // Hold off a random gap, present one request and wait for its transfer
    task automatic issue(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] word,
                         input logic [POS_W-1:0] pos, input bit typed,
                         input deque_answer_t typed_answer);
        int gap;
        deque_answer_t ans;
        if (issued % 40 == 0)
            steady = ($urandom_range(0, 9) < 3);
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        entry_data <= word;
        position   <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ans = deque_apply(req, word, pos);
        pending_answers.push_back(typed ? typed_answer : ans);
        issued++;
    endtask

    task automatic issue_random(input logic [REQ_W-1:0] req);
        deque_answer_t none;
        logic [POS_W-1:0] pos;
        none = '{default: '0};
        // mostly aim inside the held range, sometimes anywhere
        if (shadow_held != 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, shadow_held - 1));
        else
            pos = POS_W'($urandom_range(0, 255));
        issue(req, $urandom, pos, 1'b0, none);
    endtask

    // Mixed traffic over every request code
    task automatic run_mixed(input int n);
        int pick;
        logic [REQ_W-1:0] req;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)      req = REQ_PUSH_FRONT;
            else if (pick < 40) req = REQ_PUSH_BACK;
            else if (pick < 52) req = REQ_POP_FRONT;
            else if (pick < 64) req = REQ_POP_BACK;
            else if (pick < 72) req = REQ_FIRST;
            else if (pick < 80) req = REQ_LAST;
            else if (pick < 96) req = REQ_READ_POS;
            else                req = REQ_UNUSED;
            issue_random(req);
        end
    endtask

    function automatic logic [REQ_W-1:0] pick_read();
        case ($urandom_range(0, 2))
            0:       return REQ_FIRST;
            1:       return REQ_LAST;
            default: return REQ_READ_POS;
        endcase
    endfunction

    // Push until full with reads mixed in, then hit the full case
    task automatic run_fill();
        while (shadow_held != COUNT_FULL)
        begin
            if ($urandom_range(0, 3) != 0)
                issue_random($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK);
            else
                issue_random(pick_read());
        end
        repeat (4) issue_random($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK);
        issue(REQ_READ_POS, $urandom, 8'd255, 1'b0, '{default: '0});
        repeat (4) issue_random(pick_read());
    endtask

    // Pop until empty with reads mixed in, then hit the empty case
    task automatic run_drain();
        while (shadow_held != 0)
        begin
            if ($urandom_range(0, 9) < 7)
                issue_random($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK);
            else
                issue_random(pick_read());
        end
        issue_random(REQ_POP_FRONT);
        issue_random(REQ_POP_BACK);
        issue_random(pick_read());
        issue_random(pick_read());
    endtask

    // Check each result transfer against the oldest expected answer
    always @(posedge clk)
    begin : result_check
        deque_answer_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                error_count++;
                if (shown_count < SHOWN_LIMIT)
                    $display("unexpected result: data %h status %0d count %0d",
                             result_data, status, entry_count);
                shown_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result_data !== want.data || status !== want.status ||
                    entry_count !== want.count)
                begin
                    error_count++;
                    if (shown_count < SHOWN_LIMIT)
                        $display({"mismatch: expected data %h status %0d count %0d,",
                                  " got data %h status %0d count %0d"},
                                 want.data, want.status, want.count,
                                 result_data, status, entry_count);
                    shown_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[double_ended_queue_indexed_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [TABLE_ROWS];
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = '0;
        entry_data  = '0;
        position    = '0;
        shadow_head = '0;
        shadow_held = '0;

        // Empty queue: every read kind reports empty
        rows[0]  = make_row(REQ_POP_FRONT,  32'h0,         8'd0,   1, 32'h0, ST_EMPTY, 0);
        rows[1]  = make_row(REQ_POP_BACK,   32'hFFFF_FFFF, 8'd0,   1, 32'h0, ST_EMPTY, 0);
        rows[2]  = make_row(REQ_FIRST,      32'h0,         8'd0,   1, 32'h0, ST_EMPTY, 0);
        rows[3]  = make_row(REQ_LAST,       32'h0,         8'd0,   1, 32'h0, ST_EMPTY, 0);
        rows[4]  = make_row(REQ_READ_POS,   32'h0,         8'd0,   1, 32'h0, ST_EMPTY, 0);
        rows[5]  = make_row(REQ_READ_POS,   32'h0,         8'd255, 1, 32'h0, ST_EMPTY, 0);
        rows[6]  = make_row(REQ_UNUSED,     32'h0,         8'd0,   1, 32'h0, ST_OK,    0);
        // Fill both ends with extreme words
        rows[7]  = make_row(REQ_PUSH_BACK,  32'hFFFF_FFFF, 8'd255, 1, 32'h0, ST_OK,    1);
        rows[8]  = make_row(REQ_PUSH_FRONT, 32'h0000_0000, 8'd0,   1, 32'h0, ST_OK,    2);
        rows[9]  = make_row(REQ_PUSH_BACK,  32'hA5A5_5A5A, 8'd0,   1, 32'h0, ST_OK,    3);
        rows[10] = make_row(REQ_PUSH_FRONT, 32'h8000_0001, 8'd0,   1, 32'h0, ST_OK,    4);
        rows[11] = make_row(REQ_FIRST,      32'h0,         8'd0,   1, 32'h8000_0001, ST_OK, 4);
        rows[12] = make_row(REQ_LAST,       32'h0,         8'd0,   1, 32'hA5A5_5A5A, ST_OK, 4);
        rows[13] = make_row(REQ_READ_POS,   32'h0,         8'd0,   0, 32'h0, ST_OK,    0);
        rows[14] = make_row(REQ_READ_POS,   32'h0,         8'd3,   0, 32'h0, ST_OK,    0);
        // Positions at and past the count
        rows[15] = make_row(REQ_READ_POS,   32'h0,         8'd4,   1, 32'h0, ST_RANGE, 4);
        rows[16] = make_row(REQ_READ_POS,   32'h0,         8'd255, 1, 32'h0, ST_RANGE, 4);
        rows[17] = make_row(REQ_UNUSED,     32'hFFFF_FFFF, 8'd255, 1, 32'h0, ST_OK,    4);
        // Drain from both ends, popping the last entry
        rows[18] = make_row(REQ_POP_BACK,   32'h0,         8'd0,   1, 32'hA5A5_5A5A, ST_OK, 3);
        rows[19] = make_row(REQ_POP_FRONT,  32'h0,         8'd0,   1, 32'h8000_0001, ST_OK, 2);
        rows[20] = make_row(REQ_POP_FRONT,  32'h0,         8'd0,   0, 32'h0, ST_OK,    0);
        rows[21] = make_row(REQ_POP_BACK,   32'h0,         8'd0,   1, 32'hFFFF_FFFF, ST_OK, 0);
        rows[22] = make_row(REQ_POP_FRONT,  32'h0,         8'd0,   1, 32'h0, ST_EMPTY, 0);
        // Front pointer wraps below slot zero
        rows[23] = make_row(REQ_PUSH_FRONT, 32'h1234_5678, 8'd0,   0, 32'h0, ST_OK,    0);
        rows[24] = make_row(REQ_READ_POS,   32'h0,         8'd0,   0, 32'h0, ST_OK,    0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < TABLE_ROWS; i++)
            issue(rows[i].req, rows[i].word, rows[i].pos, rows[i].typed, rows[i].answer);

        issued = 0;
        run_mixed(150);
        run_fill();

        // Let every outstanding transfer come back before draining
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);

        run_drain();
        run_mixed((issued < RANDOM_ITEMS - 50) ? RANDOM_ITEMS - issued : 50);

        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[double_ended_queue_indexed_core] OK");
        else
            $display("[double_ended_queue_indexed_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/dqi_pkg.sv
rtl/core/dqi_front.sv
rtl/core/dqi_fifo.sv
rtl/core/dqi_back.sv
rtl/core/double_ended_queue_indexed_core.sv
rtl/core/dqi_checker.sv
bench/double_ended_queue_indexed_core_tb.sv
